>>> rtl/dda_pkg.sv
// Shared widths, codes and command/status types for the DDA line rasterizer.
package dda_pkg;

  // Coordinate and fixed-point geometry
  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int ACC_BITS      = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_BITS     = FRAC_BITS + 2;
  localparam int CNT_BITS      = COORD_BITS + 1;
  localparam int QUOT_BITS     = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS  = $clog2(QUOT_BITS);

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  // Item operation codes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load_start;  // start item accepted
    logic advance;     // advance item accepted
    logic div_step;    // one increment division iteration
    logic div_last;    // final iteration, commit increments
  } dda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero_len;    // endpoints on the input bus are equal
  } dda_stat_t;

endpackage

>>> rtl/dda_ctrl.sv
// Controller: stream handshakes and sequencing of the increment division.
module dda_ctrl
  import dda_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  op_t       in_op,
  input  logic      out_ready,
  input  dda_stat_t stat,
  output logic      in_ready,
  output logic      out_valid,
  output dda_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t                  state;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    accept;
  logic                    div_end;

  // Take an item only when idle and the output register frees up
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign div_end  = (div_cnt == DIV_CNT_BITS'(QUOT_BITS - 1));

  // Commands
  always_comb begin
    cmd.load_start = accept && (in_op == OP_START);
    cmd.advance    = accept && (in_op == OP_ADVANCE);
    cmd.div_step   = (state == ST_DIV);
    cmd.div_last   = (state == ST_DIV) && div_end;
  end

  // State, iteration counter, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          div_cnt <= '0;
          if (cmd.load_start && !stat.zero_len) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/dda_dpath.sv
// Datapath: endpoint setup, radix-2 increment divider, accumulators, output register.
module dda_dpath
  import dda_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dda_cmd_t                 cmd,
  input  logic [IN_DATA_BITS-1:0]  in_data,
  output dda_stat_t                stat,
  output logic [OUT_DATA_BITS-1:0] out_data,
  output logic                     out_user,
  output logic                     out_last
);

  // Unpacked endpoints
  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS-1:0] adx, ady, steps_in;

  // Line state
  logic [ACC_BITS-1:0]   acc_x, acc_y;
  logic [ACC_BITS-1:0]   acc_x_next, acc_y_next;
  logic [STEP_BITS-1:0]  step_x, step_y;
  logic [CNT_BITS-1:0]   steps_left, steps_left_next;
  logic                  line_active;

  // Divider state
  logic [COORD_BITS-1:0] div_steps;
  logic [CNT_BITS-1:0]   rem_x, rem_y, rem_x_sel, rem_y_sel;
  logic [QUOT_BITS-1:0]  quot_x, quot_y, quot_x_next, quot_y_next;
  logic                  neg_x, neg_y, ge_x, ge_y;

  // Output register
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic                  pix_valid, pix_last;

  assign sx = in_data[0 +: COORD_BITS];
  assign sy = in_data[COORD_BITS +: COORD_BITS];
  assign ex = in_data[2*COORD_BITS +: COORD_BITS];
  assign ey = in_data[3*COORD_BITS +: COORD_BITS];

  // Step count = max(|dx|, |dy|)
  always_comb begin
    adx           = (ex >= sx) ? (ex - sx) : (sx - ex);
    ady           = (ey >= sy) ? (ey - sy) : (sy - ey);
    steps_in      = (adx > ady) ? adx : ady;
    stat.zero_len = (steps_in == '0);
  end

  // Accumulator advance with sign-extended increments
  always_comb begin
    acc_x_next      = acc_x + {{(ACC_BITS-STEP_BITS){step_x[STEP_BITS-1]}}, step_x};
    acc_y_next      = acc_y + {{(ACC_BITS-STEP_BITS){step_y[STEP_BITS-1]}}, step_y};
    steps_left_next = steps_left - 1'b1;
  end

  // Restoring division step, one quotient bit per axis
  always_comb begin
    ge_x        = (rem_x >= {1'b0, div_steps});
    ge_y        = (rem_y >= {1'b0, div_steps});
    rem_x_sel   = ge_x ? (rem_x - {1'b0, div_steps}) : rem_x;
    rem_y_sel   = ge_y ? (rem_y - {1'b0, div_steps}) : rem_y;
    quot_x_next = {quot_x[QUOT_BITS-2:0], ge_x};
    quot_y_next = {quot_y[QUOT_BITS-2:0], ge_y};
  end

  // Line active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (cmd.load_start) begin
      line_active <= !stat.zero_len;
    end else if (cmd.advance && line_active) begin
      line_active <= (steps_left_next != '0);
    end
  end

  // Line setup, division and accumulation
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      acc_x      <= {1'b0, sx, 1'b1, {(FRAC_BITS-1){1'b0}}};
      acc_y      <= {1'b0, sy, 1'b1, {(FRAC_BITS-1){1'b0}}};
      steps_left <= {1'b0, steps_in};
      div_steps  <= steps_in;
      rem_x      <= {1'b0, adx};
      rem_y      <= {1'b0, ady};
      quot_x     <= '0;
      quot_y     <= '0;
      neg_x      <= (ex < sx);
      neg_y      <= (ey < sy);
      step_x     <= '0;
      step_y     <= '0;
    end else if (cmd.advance && line_active) begin
      acc_x      <= acc_x_next;
      acc_y      <= acc_y_next;
      steps_left <= steps_left_next;
    end else if (cmd.div_step) begin
      rem_x  <= {rem_x_sel[CNT_BITS-2:0], 1'b0};
      rem_y  <= {rem_y_sel[CNT_BITS-2:0], 1'b0};
      quot_x <= quot_x_next;
      quot_y <= quot_y_next;
      if (cmd.div_last) begin
        step_x <= neg_x ? (STEP_BITS'(0) - {1'b0, quot_x_next}) : {1'b0, quot_x_next};
        step_y <= neg_y ? (STEP_BITS'(0) - {1'b0, quot_y_next}) : {1'b0, quot_y_next};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      pix_x     <= sx;
      pix_y     <= sy;
      pix_valid <= 1'b1;
      pix_last  <= stat.zero_len;
    end else if (cmd.advance) begin
      if (line_active) begin
        pix_x     <= acc_x_next[FRAC_BITS +: COORD_BITS];
        pix_y     <= acc_y_next[FRAC_BITS +: COORD_BITS];
        pix_valid <= 1'b1;
        pix_last  <= (steps_left_next == '0);
      end else begin
        pix_x     <= '0;
        pix_y     <= '0;
        pix_valid <= 1'b0;
        pix_last  <= 1'b0;
      end
    end
  end

  // Pixel coordinates, zero-extended to the padded bus width
  assign out_data = OUT_DATA_BITS'({pix_y, pix_x});
  assign out_user = pix_valid;
  assign out_last = pix_last;

endmodule

>>> rtl/dda_line_rasterizer_core.sv
// Usage notes:
//   DDA line generator. Input stream s_axis carries one item per command:
//   tuser selects start (0) or advance (1); tdata holds both endpoints.
//   A start item returns the start pixel and latches the line; each advance
//   item returns the next rounded pixel, tlast marking the line's end point.
//   An advance with no line in progress returns tuser (pixel valid) = 0.
//   Output stream m_axis returns exactly one item per input item, from an
//   output register loaded when the input item is accepted.
//   An advance item needs no division. After a start item, the radix-2
//   divider forms both per-pixel increments, one quotient bit per cycle;
//   s_axis_tready is low until it is done, so no item is taken meanwhile.
//   A zero-length line skips the divider.
//   The next item is accepted while the previous result waits, as long as
//   the output register is being drained in the same cycle; if the receiver
//   stalls with a result pending, s_axis_tready drops and the result holds.
//   Reset (rst, synchronous, active high) drops any line in progress and
//   clears the output valid; no clearing pass is needed.
module dda_line_rasterizer_core
  import dda_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y, zero pad
  input  logic [0:0]               s_axis_tuser,   // operation
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // pixel_x, pixel_y, zero pad
  output logic [0:0]               m_axis_tuser,   // pixel_valid
  output logic                     m_axis_tlast    // last_pixel
);

  dda_cmd_t  cmd;
  dda_stat_t stat;
  logic      pix_valid;

  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_op     (op_t'(s_axis_tuser[0])),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .cmd       (cmd)
  );

  dda_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_axis_tdata),
    .stat     (stat),
    .out_data (m_axis_tdata),
    .out_user (pix_valid),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tuser = pix_valid;

  // No item is taken while the divider is busy
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !s_axis_tready)
    else $error("input accepted during increment division");

  // A zero-length start returns a valid, final pixel next cycle
  a_zero_len_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_start && stat.zero_len) |=> (m_axis_tvalid && m_axis_tlast && m_axis_tuser[0]))
    else $error("zero-length line did not end at its start pixel");

  // An invalid pixel carries zero coordinates and no end mark
  a_idle_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    else $error("advance without a line returned nonzero data");

  // Every start that needs division enters the division, with s_axis_tready low
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_start && !stat.zero_len) |=> (cmd.div_step && !s_axis_tready))
    else $error("division did not start after a line setup");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the DDA line rasterizer core: directed table plus random lines.
`timescale 1ns / 1ps

module tb;
  import dda_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   valid;
    logic   last;
  } pixel_t;

  typedef struct packed {
    op_t    op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   typed;  // want holds a hand-written result
    pixel_t want;
  } line_row_t;

  localparam int                RANDOM_ITEMS = 400;
  localparam int                STALL_LIMIT  = 2000;
  localparam int                HOLD_CYCLES  = 300;
  localparam int                HOLD_AT      = 120;
  localparam int                SETTLE       = 40;
  localparam int                MAX_PRINTS   = 100;
  localparam coord_t            CMAX         = {COORD_BITS{1'b1}};
  localparam logic [ACC_BITS-1:0] HALF_LSB   = ACC_BITS'(1) << (FRAC_BITS - 1);
  localparam pixel_t            NO_PIXEL     = '{'0, '0, 1'b0, 1'b0};

  // Directed items; most advances on an open line are left to the predictor
  localparam line_row_t DIRECTED [0:21] = '{
    // advance right after reset: no line, fields ignored
    '{OP_ADVANCE, CMAX, CMAX, CMAX, CMAX, 1'b1, NO_PIXEL},
    // zero-length line ends at once
    '{OP_START, 12'd5, 12'd5, 12'd5, 12'd5, 1'b1, '{12'd5, 12'd5, 1'b1, 1'b1}},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, NO_PIXEL},
    // full diagonal, later abandoned
    '{OP_START, 12'd0, 12'd0, CMAX, CMAX, 1'b1, '{12'd0, 12'd0, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, CMAX, CMAX, CMAX, CMAX, 1'b0, NO_PIXEL},
    // new start while a line is open, x decreasing
    '{OP_START, CMAX, 12'd0, 12'd4090, 12'd3, 1'b1, '{CMAX, 12'd0, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, '{12'd4090, 12'd3, 1'b1, 1'b1}},
    // line finished: no pixel
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1, NO_PIXEL},
    // horizontal on the top row
    '{OP_START, 12'd0, CMAX, 12'd3, CMAX, 1'b1, '{12'd0, CMAX, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    // vertical, y decreasing
    '{OP_START, 12'd100, 12'd200, 12'd100, 12'd198, 1'b1, '{12'd100, 12'd200, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL},
    // full reverse diagonal
    '{OP_START, CMAX, CMAX, 12'd0, 12'd0, 1'b1, '{CMAX, CMAX, 1'b1, 1'b0}},
    '{OP_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_PIXEL}
  };

  logic                     clk;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic [0:0]               s_axis_tuser  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic [0:0]               m_axis_tuser;
  logic                     m_axis_tlast;

  // Predictor state: one open line
  logic [ACC_BITS-1:0]         line_acc_x  = '0;
  logic [ACC_BITS-1:0]         line_acc_y  = '0;
  logic signed [STEP_BITS-1:0] inc_x       = '0;
  logic signed [STEP_BITS-1:0] inc_y       = '0;
  logic [CNT_BITS-1:0]         pixels_left = '0;
  logic                        line_open   = 1'b0;

  pixel_t expected_pixels [$];
  int     n_errors    = 0;
  int     n_sent      = 0;
  int     n_checked   = 0;
  bit     send_burst  = 1'b0;
  bit     recv_burst  = 1'b0;

  dda_line_rasterizer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Signed per-pixel increment, magnitude truncated toward zero
  function automatic logic [STEP_BITS-1:0] axis_increment(input coord_t from, input coord_t to,
                                                          input logic [CNT_BITS-1:0] len);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (to < from) ? 64'(from - to) : 64'(to - from);
    quo = (len != 0) ? (mag << FRAC_BITS) / 64'(len) : 64'd0;
    if (to < from) quo = -quo;
    return quo[STEP_BITS-1:0];
  endfunction

  // Advances the line state by one accepted item and returns its pixel
  function automatic pixel_t next_pixel(input op_t op, input coord_t sx, input coord_t sy,
                                        input coord_t ex, input coord_t ey);
    pixel_t              px;
    coord_t              adx;
    coord_t              ady;
    logic [CNT_BITS-1:0] len;
    px = NO_PIXEL;
    if (op == OP_START) begin
      adx = (ex >= sx) ? ex - sx : sx - ex;
      ady = (ey >= sy) ? ey - sy : sy - ey;
      len = (adx > ady) ? CNT_BITS'(adx) : CNT_BITS'(ady);
      line_acc_x  = (ACC_BITS'(sx) << FRAC_BITS) + HALF_LSB;
      line_acc_y  = (ACC_BITS'(sy) << FRAC_BITS) + HALF_LSB;
      inc_x       = axis_increment(sx, ex, len);
      inc_y       = axis_increment(sy, ey, len);
      pixels_left = len;
      line_open   = (len != 0);
      px = '{sx, sy, 1'b1, !line_open};
    end else if (line_open) begin
      line_acc_x  = line_acc_x + {{(ACC_BITS-STEP_BITS){inc_x[STEP_BITS-1]}}, inc_x};
      line_acc_y  = line_acc_y + {{(ACC_BITS-STEP_BITS){inc_y[STEP_BITS-1]}}, inc_y};
      pixels_left = pixels_left - 1'b1;
      if (pixels_left == 0) line_open = 1'b0;
      px = '{line_acc_x[FRAC_BITS +: COORD_BITS], line_acc_y[FRAC_BITS +: COORD_BITS],
             1'b1, !line_open};
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("[%0t] pixel %0d %s: expected %0d, got %0d", $realtime, n_checked, what,
               want, got);
  endtask

  // Offers one item after a random gap; predicts its pixel on acceptance
  task automatic send_item(input op_t op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           input logic typed, input pixel_t want);
    int     gap;
    pixel_t px;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_BITS'({ey, ex, sy, sx});
    do @(posedge clk); while (!s_axis_tready);
    px = next_pixel(op, sx, sy, ex, ey);
    expected_pixels.push_back(typed ? want : px);
    n_sent++;
  endtask

  // Stops offering and lets every pending pixel come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pixels.size() != 0);
  endtask

  // Endpoint near a base point, clamped to the coordinate range
  function automatic coord_t near(input coord_t base, input int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > int'(CMAX)) v = int'(CMAX);
    return coord_t'(v);
  endfunction

  // Sender: reset, directed table, random lines
  initial begin
    int     kind;
    int     adv;
    int     span;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    bit     paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].sx, DIRECTED[i].sy, DIRECTED[i].ex,
                DIRECTED[i].ey, DIRECTED[i].typed, DIRECTED[i].want);
    wait_drained();

    while (n_sent < $size(DIRECTED) + RANDOM_ITEMS) begin
      // one pause mid-run until every pixel has returned
      if (!paused && n_sent >= $size(DIRECTED) + RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      if (kind == 0) begin
        // stray advance with garbage fields
        send_item(OP_ADVANCE, sx, sy, coord_t'($urandom), coord_t'($urandom), 1'b0, NO_PIXEL);
      end else if (kind == 1) begin
        // far endpoints, abandoned after a few pixels
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
        send_item(OP_START, sx, sy, ex, ey, 1'b0, NO_PIXEL);
        adv = $urandom_range(0, 6);
        repeat (adv)
          send_item(OP_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), 1'b0, NO_PIXEL);
      end else begin
        // complete line, mostly short, zero-length now and then
        span = ($urandom_range(0, 7) == 0) ? 60 : 10;
        if (kind == 2) begin
          ex = sx;
          ey = sy;
        end else begin
          ex = near(sx, span);
          ey = near(sy, span);
        end
        send_item(OP_START, sx, sy, ex, ey, 1'b0, NO_PIXEL);
        adv = int'(pixels_left) + (($urandom_range(0, 3) == 0) ? 1 : 0);
        repeat (adv)
          send_item(OP_ADVANCE, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), 1'b0, NO_PIXEL);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, field checks
  initial begin
    int     stall;
    bit     held;
    pixel_t want;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && n_checked == HOLD_AT) begin
        // block fills up and must stall its input
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        stall = recv_burst ? 0 : $urandom_range(0, 18);
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      n_checked++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected item", 0, 1);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[COORD_BITS-1:0] !== want.x)
          report_mismatch("pixel_x", want.x, m_axis_tdata[COORD_BITS-1:0]);
        if (m_axis_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
          report_mismatch("pixel_y", want.y, m_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
        if (m_axis_tuser[0] !== want.valid)
          report_mismatch("pixel_valid", want.valid, m_axis_tuser[0]);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_pixel", want.last, m_axis_tlast);
      end
    end
  end

  // Watchdog: too long with no item moving on either side
  initial begin
    int idle;
    idle = 0;
    wait (rst == 1'b0);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else
        idle++;
    end
    $display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
